[src/rar_pkg.sv]
// Shared types and constants for the rational add/reduce block.
package rar_pkg;

  localparam int unsigned ValueWidthDef = 32;
  localparam int unsigned DataW         = 64;
  localparam int unsigned CntW          = 6;

  typedef enum logic [4:0] {
    S_IDLE,
    S_GCD1, S_GCD1_W,
    S_DIV1, S_DIV1_W,
    S_DIV2, S_DIV2_W,
    S_MUL1, S_MUL2, S_MUL3, S_MUL4, S_MUL5, S_MUL6,
    S_GCD2, S_GCD2_W,
    S_DIV3, S_DIV3_W,
    S_DIV4, S_DIV4_W,
    S_DONE
  } st_e;

endpackage

[src/rar_div.sv]
// Bit-serial restoring unsigned divider, one quotient bit per cycle.
module rar_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [rar_pkg::DataW-1:0]    num_i,
  input  logic [rar_pkg::DataW-1:0]    den_i,
  output logic [rar_pkg::DataW-1:0]    quo_o,
  output logic                         done_o
);

  logic [rar_pkg::DataW-1:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d, tmp;
  logic [rar_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic                      busy_q, busy_d, done_q, done_d, bit_v;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    tmp    = {rem_q[rar_pkg::DataW-2:0], quo_q[rar_pkg::DataW-1]};
    bit_v  = (tmp >= den_q);
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
      cnt_d  = '1;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = bit_v ? (tmp - den_q) : tmp;
      quo_d = {quo_q[rar_pkg::DataW-2:0], bit_v};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule

[src/rar_gcd.sv]
// Binary (shift/subtract) gcd unit, one step per cycle.
module rar_gcd (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [rar_pkg::DataW-1:0]    x_i,
  input  logic [rar_pkg::DataW-1:0]    y_i,
  output logic [rar_pkg::DataW-1:0]    gcd_o,
  output logic                         done_o
);

  logic [rar_pkg::DataW-1:0] x_q, x_d, y_q, y_d, res_q, res_d;
  logic [rar_pkg::CntW-1:0]  k_q, k_d;
  logic                      busy_q, busy_d, done_q, done_d;

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    k_d    = k_q;
    res_d  = res_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      x_d    = x_i;
      y_d    = y_i;
      k_d    = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (y_q == '0) begin
        res_d  = x_q << k_q;
        busy_d = 1'b0;
        done_d = 1'b1;
      end else if (!x_q[0] && !y_q[0]) begin
        x_d = x_q >> 1;
        y_d = y_q >> 1;
        k_d = k_q + 1'b1;
      end else if (!x_q[0]) begin
        x_d = x_q >> 1;
      end else if (!y_q[0]) begin
        y_d = y_q >> 1;
      end else if (x_q > y_q) begin
        x_d = y_q;
        y_d = x_q - y_q;
      end else begin
        y_d = y_q - x_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    k_q   <= k_d;
    res_q <= res_d;
  end

  assign gcd_o  = res_q;
  assign done_o = done_q;

endmodule

[src/rational_add_reduce.sv]
// Top level: adds two fractions and reduces the sum to lowest terms.
// Usage:
//   Input channel carries a_num/a_den and b_num/b_den; a transfer happens when
//   in_valid_i is high and in_stall_o is low. in_stall_o is low only while the
//   sequencer sits idle, so one item is worked on at a time.
//   Output channel carries sum_num/sum_den/same_value/overflow; a transfer
//   happens when out_valid_o is high and out_stall_i is low.
//   Sequence per item: one gcd run on the denominators, two divides on the
//   bit-serial divider, six multiply steps, a second gcd run and two more
//   divides, then the done state; the binary gcd does one shift or subtract
//   per cycle. A zero sum skips the second gcd and the last two divides.
//   A zero denominator skips the arithmetic and is returned as an overflow.
//   The result sits in an output register; a new item may be taken while it
//   waits. If the receiver stalls, the sequencer holds its finished result
//   until the output register frees up.
//   Reset clears the sequencer and the output valid; no result is pending.
//   overflow=1 means the reduced sum did not fit; sum fields are then zero.
module rational_add_reduce #(
  parameter int unsigned VALUE_WIDTH = rar_pkg::ValueWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] a_num_i,
  input  logic [30:0]        a_den_i,
  input  logic signed [31:0] b_num_i,
  input  logic [30:0]        b_den_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] sum_num_o,
  output logic [30:0]        sum_den_o,
  output logic               same_value_o,
  output logic               overflow_o
);

  localparam int unsigned DW = rar_pkg::DataW;

  rar_pkg::st_e state_q, state_d;

  // operand and working registers
  logic signed [31:0] an_q, bn_q;
  logic [30:0]        ad_q, bd_q, sa_q, sb_q;
  logic [DW-1:0]      g_q, h_q, sacc_q, l_q, t_q, prod_q, rn_q, rd_q;
  logic               same_q;

  // output register
  logic               out_valid_q;
  logic [31:0]        out_num_q;
  logic [30:0]        out_den_q;
  logic               out_same_q, out_ovf_q;

  // shared units
  logic               gcd_start, gcd_done, div_start, div_done;
  logic [DW-1:0]      gcd_x, gcd_y, gcd_res, div_num, div_den, div_quo;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic [DW-1:0]      mag, rn_hi, rd_hi;
  logic               accept, load_out, fits;

  assign accept   = in_valid_i && (state_q == rar_pkg::S_IDLE);
  assign load_out = (state_q == rar_pkg::S_DONE) && (!out_valid_q || !out_stall_i);
  assign mag      = sacc_q[DW-1] ? (~sacc_q + 1'b1) : sacc_q;
  assign mul_p    = mul_a * mul_b;

  // range check of the reduced result against VALUE_WIDTH
  assign rn_hi = DW'($signed(rn_q) >>> (VALUE_WIDTH - 1));
  assign rd_hi = rd_q >> (VALUE_WIDTH - 1);
  assign fits  = ((rn_hi == '0) || (rn_hi == '1)) && (rd_hi == '0) && (rd_q != '0);

  rar_gcd u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gcd_start),
    .x_i     (gcd_x),
    .y_i     (gcd_y),
    .gcd_o   (gcd_res),
    .done_o  (gcd_done)
  );

  rar_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .quo_o   (div_quo),
    .done_o  (div_done)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rar_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = (a_den_i == '0 || b_den_i == '0) ? rar_pkg::S_DONE : rar_pkg::S_GCD1;
        end
      end
      rar_pkg::S_GCD1:   state_d = rar_pkg::S_GCD1_W;
      rar_pkg::S_GCD1_W: if (gcd_done) state_d = rar_pkg::S_DIV1;
      rar_pkg::S_DIV1:   state_d = rar_pkg::S_DIV1_W;
      rar_pkg::S_DIV1_W: if (div_done) state_d = rar_pkg::S_DIV2;
      rar_pkg::S_DIV2:   state_d = rar_pkg::S_DIV2_W;
      rar_pkg::S_DIV2_W: if (div_done) state_d = rar_pkg::S_MUL1;
      rar_pkg::S_MUL1:   state_d = rar_pkg::S_MUL2;
      rar_pkg::S_MUL2:   state_d = rar_pkg::S_MUL3;
      rar_pkg::S_MUL3:   state_d = rar_pkg::S_MUL4;
      rar_pkg::S_MUL4:   state_d = rar_pkg::S_MUL5;
      rar_pkg::S_MUL5:   state_d = rar_pkg::S_MUL6;
      rar_pkg::S_MUL6:   state_d = (sacc_q == '0) ? rar_pkg::S_DONE : rar_pkg::S_GCD2;
      rar_pkg::S_GCD2:   state_d = rar_pkg::S_GCD2_W;
      rar_pkg::S_GCD2_W: if (gcd_done) state_d = rar_pkg::S_DIV3;
      rar_pkg::S_DIV3:   state_d = rar_pkg::S_DIV3_W;
      rar_pkg::S_DIV3_W: if (div_done) state_d = rar_pkg::S_DIV4;
      rar_pkg::S_DIV4:   state_d = rar_pkg::S_DIV4_W;
      rar_pkg::S_DIV4_W: if (div_done) state_d = rar_pkg::S_DONE;
      rar_pkg::S_DONE:   if (!out_valid_q || !out_stall_i) state_d = rar_pkg::S_IDLE;
      default:           state_d = rar_pkg::S_IDLE;
    endcase
  end

  // unit control and operand selection
  always_comb begin
    gcd_start = 1'b0;
    gcd_x     = '0;
    gcd_y     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_q)
      rar_pkg::S_GCD1: begin
        gcd_start = 1'b1;
        gcd_x     = DW'(ad_q);
        gcd_y     = DW'(bd_q);
      end
      rar_pkg::S_DIV1: begin
        div_start = 1'b1;
        div_num   = DW'(bd_q);
        div_den   = g_q;
      end
      rar_pkg::S_DIV2: begin
        div_start = 1'b1;
        div_num   = DW'(ad_q);
        div_den   = g_q;
      end
      rar_pkg::S_MUL1: begin
        mul_a = 33'(an_q);
        mul_b = $signed({2'b00, sa_q});
      end
      rar_pkg::S_MUL2: begin
        mul_a = 33'(bn_q);
        mul_b = $signed({2'b00, sb_q});
      end
      rar_pkg::S_MUL3: begin
        mul_a = $signed({2'b00, sb_q});
        mul_b = $signed({2'b00, bd_q});
      end
      rar_pkg::S_MUL4: begin
        mul_a = 33'(an_q);
        mul_b = $signed({2'b00, bd_q});
      end
      rar_pkg::S_MUL5: begin
        mul_a = 33'(bn_q);
        mul_b = $signed({2'b00, ad_q});
      end
      rar_pkg::S_GCD2: begin
        gcd_start = 1'b1;
        gcd_x     = mag;
        gcd_y     = l_q;
      end
      rar_pkg::S_DIV3: begin
        div_start = 1'b1;
        div_num   = mag;
        div_den   = h_q;
      end
      rar_pkg::S_DIV4: begin
        div_start = 1'b1;
        div_num   = l_q;
        div_den   = h_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rar_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p[DW-1:0];
    if (accept) begin
      an_q   <= a_num_i;
      ad_q   <= a_den_i;
      bn_q   <= b_num_i;
      bd_q   <= b_den_i;
      rn_q   <= '0;
      rd_q   <= '0;
      same_q <= 1'b0;
    end
    unique case (state_q)
      rar_pkg::S_GCD1_W: if (gcd_done) g_q <= gcd_res;
      rar_pkg::S_DIV1_W: if (div_done) sa_q <= div_quo[30:0];
      rar_pkg::S_DIV2_W: if (div_done) sb_q <= div_quo[30:0];
      rar_pkg::S_MUL2:   sacc_q <= prod_q;
      rar_pkg::S_MUL3:   sacc_q <= sacc_q + prod_q;
      rar_pkg::S_MUL4:   l_q <= prod_q;
      rar_pkg::S_MUL5:   t_q <= prod_q;
      rar_pkg::S_MUL6: begin
        same_q <= (t_q == prod_q);
        if (sacc_q == '0) begin
          rn_q <= '0;
          rd_q <= DW'(1);
        end
      end
      rar_pkg::S_GCD2_W: if (gcd_done) h_q <= gcd_res;
      rar_pkg::S_DIV3_W: if (div_done) rn_q <= sacc_q[DW-1] ? (~div_quo + 1'b1) : div_quo;
      rar_pkg::S_DIV4_W: if (div_done) rd_q <= div_quo;
      default: ;
    endcase
    if (load_out) begin
      out_num_q  <= fits ? rn_q[31:0] : '0;
      out_den_q  <= fits ? rd_q[30:0] : '0;
      out_same_q <= same_q;
      out_ovf_q  <= !fits;
    end
  end

  assign in_stall_o   = (state_q != rar_pkg::S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign sum_num_o    = out_num_q;
  assign sum_den_o    = out_den_q;
  assign same_value_o = out_same_q;
  assign overflow_o   = out_ovf_q;

  a_ovf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && overflow_o) |-> (sum_num_o == '0 && sum_den_o == '0))
    else $error("overflow result carries nonzero fields");

  a_den_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !overflow_o) |-> (sum_den_o != '0))
    else $error("valid result with zero denominator");

  a_zero_den_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (a_den_i == '0 || b_den_i == '0)) |=> (state_q == rar_pkg::S_DONE))
    else $error("zero denominator did not bypass arithmetic");

  a_hold_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rar_pkg::S_DONE && out_valid_q && out_stall_i) |=>
      (state_q == rar_pkg::S_DONE))
    else $error("finished result dropped while output stalled");

endmodule
